>>> hdl/brfdc_pkg.sv
// Shared types, codes and helpers for the byte ring FIFO with drop count.
// Depends on nothing; every other file in hdl/ imports it.
package brfdc_pkg;

  // Ring store depth: a power of two, one slot always left empty.
  localparam int DEPTH = 256;
  localparam int PTR_W = $clog2(DEPTH);

  // Request queue between the front and the back (power of two).
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Field widths of the transactions.
  localparam int MODE_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 32;

  // Widths used for saturation and the drop comparison.
  localparam int SAT_W = PTR_W + 8;
  localparam int CMP_W = (PTR_W > 8) ? PTR_W + 1 : 9;

  // Request modes as they arrive on the input channel.
  localparam logic [MODE_W-1:0] MODE_PUSH      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_OVERWRITE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DROP      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FIND      = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd5;

  // Operation classes handed from the front to the back.
  localparam logic [2:0] OP_NONE      = 3'd0;
  localparam logic [2:0] OP_PUSH      = 3'd1;
  localparam logic [2:0] OP_OVERWRITE = 3'd2;
  localparam logic [2:0] OP_POP       = 3'd3;
  localparam logic [2:0] OP_DROP      = 3'd4;
  localparam logic [2:0] OP_FIND      = 3'd5;
  localparam logic [2:0] OP_CLEAR     = 3'd6;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]        op;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] amount;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   out_byte;
    logic [BYTE_W-1:0]   match_offset;
    logic [BYTE_W-1:0]   fill_level;
    logic [COUNT_W-1:0]  drop_total;
  } res_t;

  // Clamp a pointer-wide count to eight bits.
  function automatic logic [7:0] sat8(input logic [PTR_W-1:0] v);
    logic [SAT_W-1:0] wide;
    wide = SAT_W'(v);
    if (wide > SAT_W'(255)) begin
      return 8'hFF;
    end
    return wide[7:0];
  endfunction

endpackage

>>> hdl/byte_ring_fifo_with_drop_count_core.sv
// Top level of the byte ring FIFO with drop count.
// Depends on brfdc_pkg, brfdc_front, brfdc_queue and brfdc_back.

// A byte FIFO kept in a 256-entry circular store with one slot always empty, so it
// holds at most 255 bytes. Each input transaction carries a mode (push, push with
// overwrite, pop, drop, find, clear) and yields exactly one result transaction with
// a status, the popped byte, the find offset, the fill level and the 32-bit drop
// count after the request. A front stage classifies each request into a two-entry
// queue; the back end owns the store, the pointers and the result register, so the
// input side keeps accepting while a result waits to be taken. Push, overwrite,
// drop, clear and the unused modes are each handled in the back end's idle state,
// so a stream of them runs at one transaction per cycle while results are taken;
// pop passes through a second state because the store's read data is registered;
// find walks the stored bytes one per cycle from the oldest. A request passes
// through the queue and then the result register before its result appears. No
// clearing pass is needed after reset: only bytes inside the fill level are ever read.
module byte_ring_fifo_with_drop_count_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [brfdc_pkg::MODE_W-1:0]   mode,
  input  logic [brfdc_pkg::BYTE_W-1:0]   data_byte,
  input  logic [brfdc_pkg::BYTE_W-1:0]   drop_amount,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [brfdc_pkg::STATUS_W-1:0] status,
  output logic [brfdc_pkg::BYTE_W-1:0]   out_byte,
  output logic [brfdc_pkg::BYTE_W-1:0]   match_offset,
  output logic [brfdc_pkg::BYTE_W-1:0]   fill_level,
  output logic [brfdc_pkg::COUNT_W-1:0]  drop_total
);
  import brfdc_pkg::*;

  req_t in_req;
  req_t q_req;
  logic q_valid;
  logic q_pop;
  res_t res;

  // The front end decodes the mode; a drop of zero bytes is folded into a no-op here.
  brfdc_front u_front (
    .mode        (mode),
    .data_byte   (data_byte),
    .drop_amount (drop_amount),
    .req         (in_req)
  );

  // The queue stalls the input only when both of its entries are occupied.
  brfdc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .q_valid  (q_valid),
    .q_req    (q_req),
    .q_pop    (q_pop)
  );

  // The back end carries out one request at a time and holds its result until taken.
  brfdc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign status       = res.status;
  assign out_byte     = res.out_byte;
  assign match_offset = res.match_offset;
  assign fill_level   = res.fill_level;
  assign drop_total   = res.drop_total;

endmodule

>>> hdl/brfdc_front.sv
// Front end: classifies an incoming request into an operation for the back end.
// Depends on brfdc_pkg.
module brfdc_front (
  input  logic [brfdc_pkg::MODE_W-1:0] mode,
  input  logic [brfdc_pkg::BYTE_W-1:0] data_byte,
  input  logic [brfdc_pkg::BYTE_W-1:0] drop_amount,
  output brfdc_pkg::req_t              req
);
  import brfdc_pkg::*;

  always_comb begin
    req.data   = data_byte;
    req.amount = drop_amount;
    unique case (mode)
      MODE_PUSH:      req.op = OP_PUSH;
      MODE_OVERWRITE: req.op = OP_OVERWRITE;
      MODE_POP:       req.op = OP_POP;
      // A drop of nothing leaves the FIFO untouched.
      MODE_DROP:      req.op = (drop_amount == '0) ? OP_NONE : OP_DROP;
      MODE_FIND:      req.op = OP_FIND;
      MODE_CLEAR:     req.op = OP_CLEAR;
      default:        req.op = OP_NONE;
    endcase
  end

endmodule

>>> hdl/brfdc_queue.sv
// Short request queue that decouples the front end from the back end.
// Depends on brfdc_pkg.
module brfdc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  brfdc_pkg::req_t in_req,
  output logic            q_valid,
  output brfdc_pkg::req_t q_req,
  input  logic            q_pop
);
  import brfdc_pkg::*;

  req_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head;
  logic [QPTR_W-1:0] tail;
  logic [QCNT_W-1:0] count;
  logic              push;

  assign in_stall = (count == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_req    = slots[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + QPTR_W'(1);
      end
      if (q_pop) begin
        head <= head + QPTR_W'(1);
      end
      if (push && !q_pop) begin
        count <= count + QCNT_W'(1);
      end else if (!push && q_pop) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= in_req;
    end
  end

endmodule

>>> hdl/brfdc_back.sv
// Back end: ring store, pointers, drop counter, find walk and result register.
// Depends on brfdc_pkg.
module brfdc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  brfdc_pkg::req_t q_req,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output brfdc_pkg::res_t res
);
  import brfdc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_FIND = 2'd2;

  logic [1:0]         state, state_next;
  logic [PTR_W-1:0]   wr, wr_next;
  logic [PTR_W-1:0]   rd, rd_next;
  logic [COUNT_W-1:0] lost, lost_next;
  logic [PTR_W-1:0]   idx, idx_next;
  logic [BYTE_W-1:0]  target, target_next;

  logic [BYTE_W-1:0]  store [DEPTH];
  logic [BYTE_W-1:0]  mem_q;
  logic               mem_we;
  logic               mem_re;
  logic [PTR_W-1:0]   rd_addr;

  logic [PTR_W-1:0]   level;
  logic               full;
  logic               empty;
  logic               out_free;
  logic               load_out;
  res_t               res_next;
  logic [CMP_W-1:0]   drop_sum;

  assign level    = wr - rd;
  assign full     = ((wr + PTR_W'(1)) == rd);
  assign empty    = (wr == rd);
  assign out_free = !out_valid || !out_stall;
  assign drop_sum = CMP_W'(rd) + CMP_W'(q_req.amount);

  always_comb begin
    state_next  = state;
    wr_next     = wr;
    rd_next     = rd;
    lost_next   = lost;
    idx_next    = idx;
    target_next = target;
    q_pop       = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    rd_addr     = rd;
    load_out    = 1'b0;
    res_next    = '0;

    unique case (state)
      S_POP: begin
        if (out_free) begin
          load_out          = 1'b1;
          rd_next           = rd + PTR_W'(1);
          res_next.out_byte = mem_q;
          res_next.fill_level = sat8(level - PTR_W'(1));
          state_next        = S_IDLE;
        end
      end
      S_FIND: begin
        if (mem_q == target) begin
          if (out_free) begin
            load_out              = 1'b1;
            res_next.match_offset = sat8(idx);
            res_next.fill_level   = sat8(level);
            state_next            = S_IDLE;
          end
        end else if ((idx + PTR_W'(1)) == level) begin
          if (out_free) begin
            load_out            = 1'b1;
            res_next.status     = STAT_NOTFOUND;
            res_next.fill_level = sat8(level);
            state_next          = S_IDLE;
          end
        end else begin
          mem_re   = 1'b1;
          rd_addr  = rd + idx + PTR_W'(1);
          idx_next = idx + PTR_W'(1);
        end
      end
      default: begin
        if (q_valid) begin
          unique case (q_req.op)
            OP_POP: begin
              if (!empty) begin
                q_pop      = 1'b1;
                mem_re     = 1'b1;
                state_next = S_POP;
              end else if (out_free) begin
                q_pop           = 1'b1;
                load_out        = 1'b1;
                res_next.status = STAT_EMPTY;
              end
            end
            OP_FIND: begin
              if (!empty) begin
                q_pop       = 1'b1;
                mem_re      = 1'b1;
                idx_next    = '0;
                target_next = q_req.data;
                state_next  = S_FIND;
              end else if (out_free) begin
                q_pop           = 1'b1;
                load_out        = 1'b1;
                res_next.status = STAT_NOTFOUND;
              end
            end
            OP_PUSH: begin
              if (out_free) begin
                q_pop    = 1'b1;
                load_out = 1'b1;
                if (full) begin
                  lost_next       = lost + COUNT_W'(1);
                  res_next.status = STAT_FULL;
                end else begin
                  mem_we  = 1'b1;
                  wr_next = wr + PTR_W'(1);
                end
              end
            end
            OP_OVERWRITE: begin
              if (out_free) begin
                q_pop    = 1'b1;
                load_out = 1'b1;
                mem_we   = 1'b1;
                wr_next  = wr + PTR_W'(1);
                if (full) begin
                  rd_next   = rd + PTR_W'(1);
                  lost_next = lost + COUNT_W'(1);
                end
              end
            end
            OP_DROP: begin
              if (out_free) begin
                q_pop    = 1'b1;
                load_out = 1'b1;
                if (CMP_W'(q_req.amount) >= CMP_W'(level)) begin
                  rd_next = wr;
                end else begin
                  rd_next = drop_sum[PTR_W-1:0];
                end
              end
            end
            OP_CLEAR: begin
              if (out_free) begin
                q_pop     = 1'b1;
                load_out  = 1'b1;
                wr_next   = '0;
                rd_next   = '0;
                lost_next = '0;
              end
            end
            default: begin
              if (out_free) begin
                q_pop    = 1'b1;
                load_out = 1'b1;
              end
            end
          endcase
          if (state_next == S_IDLE) begin
            res_next.fill_level = sat8(wr_next - rd_next);
          end
        end
      end
    endcase
    res_next.drop_total = lost_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wr        <= '0;
      rd        <= '0;
      lost      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      wr    <= wr_next;
      rd    <= rd_next;
      lost  <= lost_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    target <= target_next;
    if (load_out) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[wr] <= q_req.data;
    end
    if (mem_re) begin
      mem_q <= store[rd_addr];
    end
  end

  a_find_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND) |-> (idx < level))
    else $error("find walk ran past the fill level");

  a_pop_advances: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP && load_out) |=> (rd == $past(rd) + PTR_W'(1)))
    else $error("pop did not advance the read pointer");

  a_full_push_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && q_valid && q_req.op == OP_PUSH && full) |-> !mem_we)
    else $error("push wrote the store while full");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !load_out)
    else $error("result register overwritten while stalled");

endmodule

>>> verif/tb.sv
// Self-checking testbench for byte_ring_fifo_with_drop_count_core: a scoreboard class predicts
// every result from the accepted requests, while a task drives the input channel and a receiver the output stall.
// Depends on brfdc_pkg and the core; idling and back-pressure vary from phase to phase.
module tb;
  import brfdc_pkg::*;

  // The two mode codes that the block treats as no-operations.
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

  // Cycles without any transaction before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_ITEMS = 240;
  localparam int TAIL_CYCLES = 20;

  // Mirror of the FIFO: store, pointers and drop counter, plus the queue of results
  // that the accepted requests are still owed.
  class fifo_scoreboard;
    logic [BYTE_W-1:0]  store [DEPTH];
    logic [PTR_W-1:0]   wr_ptr;
    logic [PTR_W-1:0]   rd_ptr;
    logic [COUNT_W-1:0] lost;
    res_t               owed_q [$];
    int                 error_count;

    function new();
      wr_ptr = '0;
      rd_ptr = '0;
      lost = '0;
      error_count = 0;
    endfunction

    function int unsigned level();
      return int'(PTR_W'(wr_ptr - rd_ptr));
    endfunction

    function bit is_full();
      return PTR_W'(wr_ptr + 1'b1) == rd_ptr;
    endfunction

    // Counts and offsets wider than a byte are clamped rather than wrapped.
    function logic [7:0] clamp8(int unsigned v);
      return (v > 255) ? 8'hFF : v[7:0];
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void note_request(logic [MODE_W-1:0] m, logic [BYTE_W-1:0] d,
                               logic [BYTE_W-1:0] a);
      res_t        want;
      int unsigned lvl;
      int unsigned i;
      bit          hit;
      want = '0;
      want.status = STAT_OK;
      case (m)
        MODE_PUSH: begin
          if (is_full()) begin
            lost = lost + 1'b1;
            want.status = STAT_FULL;
          end else begin
            store[wr_ptr] = d;
            wr_ptr = wr_ptr + 1'b1;
          end
        end
        MODE_OVERWRITE: begin
          // When full, the oldest byte makes room and is counted as lost.
          if (is_full()) begin
            rd_ptr = rd_ptr + 1'b1;
            lost = lost + 1'b1;
          end
          store[wr_ptr] = d;
          wr_ptr = wr_ptr + 1'b1;
        end
        MODE_POP: begin
          if (wr_ptr == rd_ptr) begin
            want.status = STAT_EMPTY;
          end else begin
            want.out_byte = store[rd_ptr];
            rd_ptr = rd_ptr + 1'b1;
          end
        end
        MODE_DROP: begin
          if (a != '0) begin
            if (int'(a) >= level()) begin
              rd_ptr = wr_ptr;
            end else begin
              rd_ptr = PTR_W'(rd_ptr + a);
            end
          end
        end
        MODE_FIND: begin
          lvl = level();
          hit = 1'b0;
          for (i = 0; i < lvl; i++) begin
            if (store[PTR_W'(rd_ptr + i)] == d) begin
              hit = 1'b1;
              break;
            end
          end
          if (hit) begin
            want.match_offset = clamp8(i);
          end else begin
            want.status = STAT_NOTFOUND;
          end
        end
        MODE_CLEAR: begin
          wr_ptr = '0;
          rd_ptr = '0;
          lost = '0;
        end
        default: begin
        end
      endcase
      want.fill_level = clamp8(level());
      want.drop_total = lost;
      owed_q.push_back(want);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      error_count++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (owed_q.size() == 0) begin
        report("result transaction with no request outstanding");
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d expected %0d", got.status, want.status));
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte got %0h expected %0h", got.out_byte, want.out_byte));
      if (got.match_offset !== want.match_offset)
        report($sformatf("match_offset got %0d expected %0d",
                         got.match_offset, want.match_offset));
      if (got.fill_level !== want.fill_level)
        report($sformatf("fill_level got %0d expected %0d",
                         got.fill_level, want.fill_level));
      if (got.drop_total !== want.drop_total)
        report($sformatf("drop_total got %0d expected %0d",
                         got.drop_total, want.drop_total));
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [MODE_W-1:0]   mode;
  logic [BYTE_W-1:0]   data_byte;
  logic [BYTE_W-1:0]   drop_amount;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   out_byte;
  logic [BYTE_W-1:0]   match_offset;
  logic [BYTE_W-1:0]   fill_level;
  logic [COUNT_W-1:0]  drop_total;

  fifo_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_left;
  int quiet_cycles;

  byte_ring_fifo_with_drop_count_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .data_byte    (data_byte),
    .drop_amount  (drop_amount),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_byte     (out_byte),
    .match_offset (match_offset),
    .fill_level   (fill_level),
    .drop_total   (drop_total)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one request, after a random idle gap, and hold it until the block takes it.
  task issue_request(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] d,
                     input logic [BYTE_W-1:0] a);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    data_byte   <= d;
    drop_amount <= a;
    do @(posedge clk); while (in_stall);
    sb.note_request(m, d, a);
  endtask

  // Small byte values come up often so that finds hit stored bytes.
  function logic [BYTE_W-1:0] pick_byte();
    return $urandom_range(1) ? BYTE_W'($urandom_range(15)) : BYTE_W'($urandom_range(255));
  endfunction

  task issue_random_request();
    int                r;
    logic [MODE_W-1:0] m;
    logic [BYTE_W-1:0] a;
    r = $urandom_range(99);
    if (r < 30)      m = MODE_PUSH;
    else if (r < 40) m = MODE_OVERWRITE;
    else if (r < 65) m = MODE_POP;
    else if (r < 73) m = MODE_DROP;
    else if (r < 90) m = MODE_FIND;
    else if (r < 92) m = MODE_CLEAR;
    else if (r < 96) m = MODE_SPARE_A;
    else             m = MODE_SPARE_B;
    case ($urandom_range(3))
      0:       a = '0;
      1:       a = BYTE_W'($urandom_range(1, 4));
      2:       a = 8'hFF;
      default: a = BYTE_W'($urandom_range(255));
    endcase
    issue_request(m, pick_byte(), a);
  endtask

  // Receiver: checks each accepted result, then chooses the stall for the next cycle.
  // A requested hold-off is counted down here, independently of the sender.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall) begin
        sb.check_result('{status, out_byte, match_offset, fill_level, drop_total});
      end
      if (hold_off_left > 0) begin
        out_stall <= 1'b1;
        hold_off_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: gives up when no transaction has moved on either side for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int n;
    int len;
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_left = 0;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    mode        <= MODE_PUSH;
    data_byte   <= '0;
    drop_amount <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty-FIFO corners, every mode, byte extremes and exact drops.
    issue_request(MODE_POP, 8'h00, 8'h00);
    issue_request(MODE_FIND, 8'h00, 8'hFF);
    issue_request(MODE_DROP, 8'hFF, 8'h00);
    issue_request(MODE_DROP, 8'h00, 8'hFF);
    issue_request(MODE_PUSH, 8'h00, 8'h00);
    issue_request(MODE_PUSH, 8'hFF, 8'hFF);
    issue_request(MODE_OVERWRITE, 8'hA5, 8'h00);
    issue_request(MODE_FIND, 8'hFF, 8'h00);
    issue_request(MODE_FIND, 8'h00, 8'h00);
    issue_request(MODE_FIND, 8'h5A, 8'h00);
    issue_request(MODE_DROP, 8'h00, 8'h00);
    issue_request(MODE_DROP, 8'h00, 8'h01);
    issue_request(MODE_POP, 8'h00, 8'h00);
    issue_request(MODE_SPARE_A, 8'hFF, 8'hFF);
    issue_request(MODE_SPARE_B, 8'hFF, 8'hFF);
    issue_request(MODE_POP, 8'h00, 8'h00);
    issue_request(MODE_POP, 8'h00, 8'h00);
    issue_request(MODE_PUSH, 8'h11, 8'h00);
    issue_request(MODE_PUSH, 8'h22, 8'h00);
    issue_request(MODE_DROP, 8'h00, 8'h02);
    issue_request(MODE_PUSH, 8'h33, 8'h00);
    issue_request(MODE_CLEAR, 8'h00, 8'h00);
    issue_request(MODE_POP, 8'h00, 8'h00);

    // Back-pressure: the receiver holds off while pushes keep coming, so the block
    // backs up and stalls its input. The pushes also run the FIFO full, then past full.
    hold_off_left = HOLD_OFF_CYCLES;
    repeat (262) issue_request(MODE_PUSH, BYTE_W'($urandom_range(254)), 8'h00);
    issue_request(MODE_FIND, 8'hFF, 8'h00);
    issue_request(MODE_OVERWRITE, 8'hFF, 8'h00);
    issue_request(MODE_OVERWRITE, 8'h80, 8'h00);
    issue_request(MODE_FIND, 8'hFF, 8'h00);
    issue_request(MODE_PUSH, 8'h7F, 8'h00);
    issue_request(MODE_DROP, 8'h00, 8'hFF);

    // Random part in four idling phases.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 62;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 62;
        end
        default: begin
          send_idle_pct = 31;
          recv_stall_pct = 31;
        end
      endcase
      n = 0;
      while (n < PHASE_ITEMS) begin
        case ($urandom_range(7))
          0: begin
            // A run of pushes builds up the fill level.
            len = $urandom_range(10, 40);
            repeat (len) begin
              issue_request($urandom_range(4) == 0 ? MODE_OVERWRITE : MODE_PUSH,
                            pick_byte(), BYTE_W'($urandom_range(255)));
            end
            n += len;
          end
          1: begin
            len = $urandom_range(5, 20);
            repeat (len) issue_request(MODE_POP, pick_byte(), BYTE_W'($urandom_range(255)));
            n += len;
          end
          default: begin
            issue_random_request();
            n++;
          end
        endcase
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
